// ===== src/murmur_hash_64_unit_defines.svh =====
// ----------------------------------------------------------------------------
// murmur_hash_64_unit_defines
// Assertion macros shared by the hash unit RTL.
// ----------------------------------------------------------------------------
`ifndef MURMUR_HASH_64_UNIT_DEFINES_SVH
`define MURMUR_HASH_64_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define MH64_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define MH64_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/mh64_pkg.sv =====
// ----------------------------------------------------------------------------
// mh64_pkg
// Constants, types and helper functions of the 64-bit murmur hash unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mh64_pkg;

   localparam logic [63:0] MIX_MULT   = 64'hc6a4a7935bd1e995;
   localparam int          MIX_SHIFT  = 47;
   localparam int          LEN_W      = 31;
   localparam int          WORD_W     = 64;
   localparam int          CSR_ADDR_W = 4;
   localparam int          CSR_DATA_W = 64;

   // Register index taken from paddr[3] (8-byte spacing).
   localparam logic        CSR_IDX_SEED = 1'b0;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] operand;
   } mul_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [WORD_W-1:0] product;
   } mul_rsp_type;

   function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] v);
      xorshift = v ^ (v >> MIX_SHIFT);
   endfunction

   // Keep the n low bytes of a word.
   function automatic logic [WORD_W-1:0] tail_mask(input logic [2:0] n);
      logic [WORD_W-1:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (3'(i) < n) begin
            m[i*8 +: 8] = 8'hff;
         end
      end
      tail_mask = m;
   endfunction

endpackage

`default_nettype wire

// ===== src/murmur_hash_64_unit.sv =====
// ----------------------------------------------------------------------------
// murmur_hash_64_unit
// Streaming MurmurHash64A engine with an APB seed register.
// ----------------------------------------------------------------------------
// Keys arrive as little-endian 64-bit words on the req_ stream, key length in
// the item flagged first (tuser), end of key on tlast; one 64-bit hash leaves
// on the rsp_ stream for each item with tlast set. Every multiply by the
// mixing constant runs on one shared 32x32 multiplier, and the sequencer
// waits for its done strobe after each one. An item is accepted, dispatched
// and checked for last; a full word adds the K1, K2 and MIXH multiplies, a
// partial tail one multiply, and no bytes remaining none; a first item adds
// the length multiply and a last item adds the finalizer multiply and the
// handover to the output register. req_tready is high only while the
// sequencer is idle; a finished hash waits in an output register and holds off
// the next item only when that item's hash is ready before the register drains.
`default_nettype none

`include "murmur_hash_64_unit_defines.svh"

module murmur_hash_64_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // req_tdata: data_word [63:0], key_length [94:64], zero [95]
   input  wire logic [95:0]                      req_tdata,
   // req_tuser: first_word [0]
   input  wire logic [0:0]                       req_tuser,
   input  wire logic                             req_tlast,
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   // rsp_tdata: hash_value [63:0]
   output      logic [63:0]                      rsp_tdata,
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [mh64_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [mh64_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output      logic [mh64_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output      logic                             csr_pready
);
   import mh64_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SEED = 4'd1;
   localparam logic [3:0] ST_DISP = 4'd2;
   localparam logic [3:0] ST_K1   = 4'd3;
   localparam logic [3:0] ST_K2   = 4'd4;
   localparam logic [3:0] ST_MIXH = 4'd5;
   localparam logic [3:0] ST_TAIL = 4'd6;
   localparam logic [3:0] ST_LAST = 4'd7;
   localparam logic [3:0] ST_FIN  = 4'd8;
   localparam logic [3:0] ST_EMIT = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic              last_ff, last_in;
   logic [WORD_W-1:0] out_ff, out_in;
   logic              out_valid_ff, out_valid_in;

   logic [WORD_W-1:0] hash_seed;
   mul_req_type       mul_req;
   mul_rsp_type       mul_rsp;

   mh64_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .hash_seed   (hash_seed)
   );

   mh64_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      len_in       = len_ff;
      word_in      = word_ff;
      last_in      = last_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      mul_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               word_in = req_tdata[63:0];
               len_in  = req_tdata[94:64];
               last_in = req_tlast;
               if (req_tuser[0]) begin
                  mul_req.start   = 1'b1;
                  mul_req.operand = {{(WORD_W-LEN_W){1'b0}}, req_tdata[94:64]};
                  state_in        = ST_SEED;
               end else begin
                  state_in = ST_DISP;
               end
            end
         end
         ST_SEED: begin
            if (mul_rsp.done) begin
               acc_in   = hash_seed ^ mul_rsp.product;
               rem_in   = len_ff;
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            if (rem_ff[LEN_W-1:3] != '0) begin
               mul_req.start   = 1'b1;
               mul_req.operand = word_ff;
               rem_in          = rem_ff - LEN_W'(8);
               state_in        = ST_K1;
            end else if (rem_ff[2:0] != 3'd0) begin
               // fold the tail bytes in, then one multiply
               mul_req.start   = 1'b1;
               mul_req.operand = acc_ff ^ (word_ff & tail_mask(rem_ff[2:0]));
               rem_in          = '0;
               state_in        = ST_TAIL;
            end else begin
               state_in = ST_LAST;
            end
         end
         ST_K1: begin
            if (mul_rsp.done) begin
               mul_req.start   = 1'b1;
               mul_req.operand = xorshift(mul_rsp.product);
               state_in        = ST_K2;
            end
         end
         ST_K2: begin
            if (mul_rsp.done) begin
               mul_req.start   = 1'b1;
               mul_req.operand = acc_ff ^ mul_rsp.product;
               state_in        = ST_MIXH;
            end
         end
         ST_MIXH, ST_TAIL: begin
            if (mul_rsp.done) begin
               acc_in   = mul_rsp.product;
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            if (last_ff) begin
               // accumulator keeps its pre-finalizer value
               mul_req.start   = 1'b1;
               mul_req.operand = xorshift(acc_ff);
               rem_in          = '0;
               state_in        = ST_FIN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FIN: begin
            if (mul_rsp.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!out_valid_ff || rsp_tready) begin
               out_in       = xorshift(mul_rsp.product);
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
      len_ff  <= len_in;
      word_ff <= word_in;
      last_ff <= last_in;
      out_ff  <= out_in;
   end

   `MH64_ASSERT_NOW(a_mul_start_idle, mul_req.start, !mul_rsp.busy, "multiplier restarted while busy")
   `MH64_ASSERT_NEXT(a_accept_leaves_idle, req_tvalid && req_tready, state_ff != ST_IDLE, "sequencer stayed idle after a transfer")
   `MH64_ASSERT_NEXT(a_emit_waits, state_ff == ST_EMIT && out_valid_ff && !rsp_tready, state_ff == ST_EMIT && out_valid_ff, "pending hash overwritten")
   `MH64_ASSERT_NEXT(a_fin_to_emit, state_ff == ST_FIN && mul_rsp.done, state_ff == ST_EMIT, "finalizer product not taken")

endmodule

`default_nettype wire

// ===== src/mh64_mul.sv =====
// ----------------------------------------------------------------------------
// mh64_mul
// Shared multiplier: low 64 bits of operand times the mixing constant,
// built from one 32x32 multiplier in the steps STEP_LO, STEP_HI and STEP_CROSS.
// ----------------------------------------------------------------------------
`default_nettype none

module mh64_mul (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mh64_pkg::mul_req_type mul_req,
   output      mh64_pkg::mul_rsp_type mul_rsp
);
   import mh64_pkg::*;

   localparam logic [1:0] STEP_LO    = 2'd0;  // aL * mL, full product
   localparam logic [1:0] STEP_HI    = 2'd1;  // aH * mL, low half into upper word
   localparam logic [1:0] STEP_CROSS = 2'd2;  // aL * mH, low half into upper word

   logic [WORD_W-1:0] a_ff, a_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [1:0]        step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [31:0]       op_x;
   logic [31:0]       op_y;
   logic [63:0]       part;

   always_comb begin
      op_x = (step_ff == STEP_HI) ? a_ff[63:32] : a_ff[31:0];
      op_y = (step_ff == STEP_CROSS) ? MIX_MULT[63:32] : MIX_MULT[31:0];
      part = op_x * op_y;

      a_in    = a_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (mul_req.start) begin
         a_in    = mul_req.operand;
         step_in = STEP_LO;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         case (step_ff)
            STEP_LO: begin
               acc_in  = part;
               step_in = STEP_HI;
            end
            STEP_HI: begin
               acc_in  = acc_ff + {part[31:0], 32'b0};
               step_in = STEP_CROSS;
            end
            STEP_CROSS: begin
               acc_in  = acc_ff + {part[31:0], 32'b0};
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= STEP_LO;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      a_ff   <= a_in;
      acc_ff <= acc_in;
   end

   assign mul_rsp.busy    = busy_ff;
   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule

`default_nettype wire

// ===== src/mh64_csr.sv =====
// ----------------------------------------------------------------------------
// mh64_csr
// APB register file holding the hash seed.
// ----------------------------------------------------------------------------
`default_nettype none

module mh64_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [mh64_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [mh64_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output      logic [mh64_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output      logic                             csr_pready,
   output      logic [mh64_pkg::WORD_W-1:0]      hash_seed
);
   import mh64_pkg::*;

   logic [WORD_W-1:0] seed_ff, seed_in;
   logic              reg_idx;
   logic              wr_seed;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1];
   assign csr_pready = 1'b1;
   assign wr_seed    = csr_psel & csr_penable & csr_pwrite & csr_pready &
                       (reg_idx == CSR_IDX_SEED);

   always_comb begin
      seed_in = wr_seed ? csr_pwdata : seed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   assign csr_prdata = (reg_idx == CSR_IDX_SEED) ? seed_ff : '0;
   assign hash_seed  = seed_ff;

endmodule

`default_nettype wire

// ===== tb/tb_murmur_hash_64_unit.sv =====
// ----------------------------------------------------------------------------
// tb_murmur_hash_64_unit
// Self-checking bench for the streaming MurmurHash64A unit: keys go in as
// 64-bit words, every finished hash is compared against a predicted value.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_murmur_hash_64_unit;
   import mh64_pkg::*;

   localparam int RESET_CYCLES   = 10;
   localparam int SETTLE_CYCLES  = 60;
   localparam int STALL_LIMIT    = 3000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int IDLE_PCT       = 13;
   localparam int PHASE_ITEMS    = 145;
   localparam int MAX_REPORTS    = 10;

   // Register index sits in paddr[3].
   localparam logic [CSR_ADDR_W-1:0] SEED_ADDR = CSR_ADDR_W'({CSR_IDX_SEED, 3'b000});

   class key_hash_board;
      logic [WORD_W-1:0] seed;
      logic [WORD_W-1:0] acc;
      logic [LEN_W-1:0]  bytes_left;
      logic [WORD_W-1:0] due_hashes[$];
      int                mismatches;

      function new();
         seed       = '0;
         acc        = '0;
         bytes_left = '0;
         mismatches = 0;
      endfunction

      function void take_word(input logic [WORD_W-1:0] word, input logic [LEN_W-1:0] key_len,
                              input logic is_first, input logic is_last);
         logic [WORD_W-1:0] k;
         logic [WORD_W-1:0] h;
         if (is_first) begin
            acc        = seed ^ (WORD_W'(key_len) * MIX_MULT);
            bytes_left = key_len;
         end
         if (bytes_left >= 8) begin
            k          = word * MIX_MULT;
            k          = k ^ (k >> MIX_SHIFT);
            k          = k * MIX_MULT;
            acc        = (acc ^ k) * MIX_MULT;
            bytes_left = bytes_left - 8;
         end else if (bytes_left > 0) begin
            // fold in only the tail bytes still owed
            acc        = (acc ^ (word & ((64'd1 << (8 * bytes_left)) - 64'd1))) * MIX_MULT;
            bytes_left = '0;
         end
         if (is_last) begin
            h = acc ^ (acc >> MIX_SHIFT);
            h = h * MIX_MULT;
            h = h ^ (h >> MIX_SHIFT);
            due_hashes.push_back(h);
            bytes_left = '0;
         end
      endfunction

      function void check_hash(input logic [WORD_W-1:0] got);
         logic [WORD_W-1:0] want;
         if (due_hashes.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("unexpected hash %h with none pending", got);
            mismatches++;
         end else begin
            want = due_hashes.pop_front();
            if (got !== want) begin
               if (mismatches < MAX_REPORTS)
                  $display("hash_value mismatch: expected %h, got %h", want, got);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return due_hashes.size();
      endfunction
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic [95:0]           req_tdata   = '0;   // data_word [63:0], key_length [94:64], zero [95]
   logic [0:0]            req_tuser   = '0;   // first_word [0]
   logic                  req_tlast   = 1'b0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [63:0]           rsp_tdata;          // hash_value [63:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bit no_idle      = 1'b0;
   bit rsp_hold_req = 1'b0;

   key_hash_board hashes = new();

   murmur_hash_64_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Sample both streams at the edge, before the driven values move.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            hashes.take_word(req_tdata[WORD_W-1:0], req_tdata[WORD_W +: LEN_W],
                             req_tuser[0], req_tlast);
         if (rsp_tvalid && rsp_tready)
            hashes.check_hash(rsp_tdata);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || csr_psel || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_murmur_hash_64_unit: done, errors");
      $finish;
   end

   // Result side: random back-pressure, plus one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end
         rsp_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   function automatic logic [WORD_W-1:0] any_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [LEN_W-1:0] any_len();
      return LEN_W'($urandom);
   endfunction

   function automatic int words_for(input int n_bytes);
      return (n_bytes == 0) ? 1 : (n_bytes + 7) / 8;
   endfunction

   task automatic send_item(input logic [WORD_W-1:0] word, input logic [LEN_W-1:0] key_len,
                            input logic is_first, input logic is_last);
      if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      req_tdata  <= {1'b0, key_len, word};
      req_tuser  <= is_first;
      req_tlast  <= is_last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_key(input logic [LEN_W-1:0] key_len, input int words);
      for (int i = 0; i < words; i++)
         send_item(any_word(), (i == 0) ? key_len : any_len(), i == 0, i == words - 1);
   endtask

   // Step past a clock edge first so the last transfer has reached the board.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (hashes.pending() != 0) @(posedge clock);
   endtask

   // Items without a hash may still be in flight; give them time to finish.
   task automatic settle();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input logic [WORD_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= SEED_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      hashes.seed = value;
   endtask

   task automatic run_directed();
      // words before any key was started: nothing owed, accumulator still zero
      send_item('1, 31'd5, 1'b0, 1'b0);
      send_item(64'h0123_4567_89ab_cdef, 31'd0, 1'b0, 1'b1);
      // empty key, data ignored
      send_item('1, 31'd0, 1'b1, 1'b1);
      // short keys in one word, upper bytes must be dropped
      send_item('1, 31'd3, 1'b1, 1'b1);
      send_item(64'hfedc_ba98_7654_3210, 31'd7, 1'b1, 1'b1);
      send_item('1, 31'd8, 1'b1, 1'b1);
      send_item('0, 31'd8, 1'b1, 1'b1);
      // full word then a five-byte tail
      send_item(64'h0807_0605_0403_0201, 31'd13, 1'b1, 1'b0);
      send_item(64'hffff_ff10_0f0e_0d0c, '1, 1'b0, 1'b1);
      // key closed early, owed bytes dropped
      send_item(64'h5555_aaaa_5555_aaaa, 31'd24, 1'b1, 1'b0);
      send_item(64'haaaa_5555_aaaa_5555, 31'd0, 1'b0, 1'b1);
      // words past the end of the key leave the hash alone
      send_item(64'h1122_3344_5566_7788, 31'd8, 1'b1, 1'b0);
      send_item('1, '1, 1'b0, 1'b0);
      send_item('1, 31'd0, 1'b0, 1'b1);
      // largest length, cut short
      send_item('1, '1, 1'b1, 1'b0);
      send_item('0, '1, 1'b0, 1'b1);
      // restart in the middle of a key
      send_item(64'hdead_beef_0bad_f00d, 31'd16, 1'b1, 1'b0);
      send_item(64'h0000_0000_cafe_babe, 31'd9, 1'b1, 1'b0);
      send_item(64'h7f7f_7f7f_7f7f_7f80, 31'd0, 1'b0, 1'b1);
      // empty key opened without last, closed by the next word
      send_item('1, 31'd0, 1'b1, 1'b0);
      send_item('1, 31'd0, 1'b0, 1'b1);
      send_item('1, 31'd16, 1'b1, 1'b0);
      send_item('0, 31'd0, 1'b0, 1'b1);
   endtask

   task automatic run_random(input int n_items);
      logic [LEN_W-1:0] key_len;
      int               sent;
      int               pick;
      int               words;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            key_len = ($urandom_range(3) == 0) ? LEN_W'($urandom_range(41, 120))
                                               : LEN_W'($urandom_range(0, 40));
            words   = words_for(int'(key_len));
            send_key(key_len, words);
         end else if (pick < 88) begin
            // truncated key, usually with a huge length
            key_len = any_len();
            words   = $urandom_range(1, 3);
            send_key(key_len, words);
         end else if (pick < 95) begin
            // overlong key: extra words after the length is used up
            key_len = LEN_W'($urandom_range(0, 24));
            words   = words_for(int'(key_len)) + $urandom_range(1, 3);
            send_key(key_len, words);
         end else begin
            words = 1;
            send_item(any_word(), any_len(), 1'b0, 1'($urandom_range(1)));
         end
         sent += words;
      end
   endtask

   initial begin
      logic [WORD_W-1:0] seed_value;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      settle();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       seed_value = '1;
            1:       seed_value = '0;
            3:       seed_value = 64'h1;
            4:       seed_value = 64'h8000_0000_0000_0000;
            default: seed_value = any_word();
         endcase
         write_seed(seed_value);
         no_idle = (phase == 2);
         if (phase == 3)
            rsp_hold_req = 1'b1;
         if (phase == 4) begin
            run_random(PHASE_ITEMS / 2);
            drain_results();
            run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
         end else begin
            run_random(PHASE_ITEMS);
         end
         no_idle = 1'b0;
         settle();
      end
      if (hashes.mismatches == 0 && hashes.pending() == 0)
         $display("tb_murmur_hash_64_unit: done, clean");
      else
         $display("tb_murmur_hash_64_unit: done, errors");
      $finish;
   end

endmodule
